[sv/bmirq_pkg.sv]
// ----------------------------------------------------------------------------
// bmirq_pkg
// Shared types and constants for the bank mapper with IRQ timer and paged RAM.
// ----------------------------------------------------------------------------
`default_nettype none

package bmirq_pkg;

  // Request kinds carried in the mode field
  typedef enum logic [2:0] {
    MODE_WR   = 3'd0,
    MODE_RD   = 3'd1,
    MODE_TICK = 3'd2,
    MODE_CHR  = 3'd3,
    MODE_PRG  = 3'd4
  } mode_t;

  // Window register map
  localparam logic [12:0] CHR_LO      = 13'h1ef0;
  localparam logic [12:0] CHR_HI      = 13'h1ef5;
  localparam logic [12:0] REG_MIRROR  = 13'h1ef6;
  localparam logic [12:0] UNLOCK_LO   = 13'h1ef7;
  localparam logic [12:0] UNLOCK_HI   = 13'h1ef9;
  localparam logic [12:0] PRG_LO      = 13'h1efa;
  localparam logic [12:0] PRG_HI      = 13'h1efc;
  localparam logic [12:0] REG_RELOAD  = 13'h1efd;
  localparam logic [12:0] REG_CONTROL = 13'h1efe;
  localparam logic [12:0] REG_IRQ_ACK = 13'h1eff;

  // RAM unlock keys and region limits
  localparam logic [7:0]  UNLOCK0_KEY = 8'hca;
  localparam logic [7:0]  UNLOCK1_KEY = 8'h69;
  localparam logic [7:0]  UNLOCK2_KEY = 8'h84;
  localparam logic [12:0] REGION0_END = 13'h0800;
  localparam logic [12:0] REGION1_END = 13'h1000;
  localparam logic [12:0] REGION2_END = 13'h1400;

  // Reset values
  localparam logic [5:0]  PRG_SIZE_RESET  = 6'd16;
  localparam logic [5:0]  PRG_SLOT2_RESET = 6'd30;

  // Output queue depth
  localparam int OQ_DEPTH = 4;

  // RAM access request, issued in the accept cycle
  typedef struct packed {
    logic        wr;
    logic        rd;
    logic [12:0] off;
    logic [7:0]  data;
  } ram_req_t;

  // Register-side result of one request
  typedef struct packed {
    logic [18:0] mapped;
    logic        irq;
    logic        mirror;
  } item_res_t;

  // Complete result item, read_data in the low bits
  typedef struct packed {
    logic        mirror;
    logic        irq;
    logic [18:0] mapped;
    logic [7:0]  read_data;
  } out_item_t;

endpackage

`default_nettype wire

[sv/bmirq_regs.sv]
// ----------------------------------------------------------------------------
// bmirq_regs
// Mapper register file, IRQ down counter, address translation and RAM unlock.
// ----------------------------------------------------------------------------
`default_nettype none

module bmirq_regs #(
  parameter int RAM_BYTES = 5120
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wr_en,
  input  wire logic [5:0]           cfg_wr_data,
  input  wire logic                 accept,
  input  wire bmirq_pkg::mode_t     mode,
  input  wire logic [14:0]          address,
  input  wire logic [7:0]           data,
  output bmirq_pkg::ram_req_t       ram_req,
  output bmirq_pkg::item_res_t      res
);

  localparam logic [13:0] RAM_END = 14'(RAM_BYTES);

  logic [5:0][7:0] chr_regs,   chr_regs_next;
  logic            chr_built,  chr_built_next;
  logic            chr_swap,   chr_swap_next;
  logic            mirror_bit, mirror_bit_next;
  logic [2:0][5:0] prg_banks,  prg_banks_next;
  logic [2:0][7:0] unlock,     unlock_next;
  logic [7:0]      reload,     reload_next;
  logic [7:0]      control,    control_next;
  logic [12:0]     count,      count_next;
  logic            pending,    pending_next;
  logic [5:0]      prg_size;

  logic [12:0] off;
  logic        ram_open;
  logic [12:0] reload_ctl;
  logic [12:0] reload_ack;
  logic [12:0] count_tick;
  logic [2:0]  chr_slot;
  logic [7:0]  chr_bank;
  logic [5:0]  size_eff;
  logic [6:0]  size_mask_w;
  logic [5:0]  prg_mask;
  logic [1:0]  prg_slot;
  logic [5:0]  prg_bank;
  logic [18:0] mapped;

  function automatic logic [5:0] reverse6(input logic [5:0] v);
    logic [5:0] r;
    for (int i = 0; i < 6; i++) begin
      r[5 - i] = v[i];
    end
    return r;
  endfunction

  assign off = address[12:0];

  // Unlock check against the current unlock bytes
  always_comb begin
    ram_open = ({1'b0, off} < RAM_END) &&
               (((off < bmirq_pkg::REGION0_END) && (unlock[0] == bmirq_pkg::UNLOCK0_KEY)) ||
                ((off < bmirq_pkg::REGION1_END) && (unlock[1] == bmirq_pkg::UNLOCK1_KEY)) ||
                ((off < bmirq_pkg::REGION2_END) && (unlock[2] == bmirq_pkg::UNLOCK2_KEY)));
  end

  // Counter reload values: 16*(v+2) or 17, 16*(v+1) or 1
  always_comb begin
    reload_ctl = (reload == 8'd0) ? 13'd17 : {({1'b0, reload} + 9'd2), 4'b0000};
    reload_ack = (reload == 8'd0) ? 13'd1  : {({1'b0, reload} + 9'd1), 4'b0000};
  end

  // Count down on a tick when enabled, not halted and not already zero
  assign count_tick = (control[0] && !control[2] && (count != 13'd0)) ?
                      (count - 13'd1) : count;

  // CHR slot lookup; before any bank or mirror register write the slots map linearly
  always_comb begin
    logic [2:0] t;
    chr_slot = address[12:10];
    t        = chr_slot ^ {chr_swap, 2'b00};
    case (t)
      3'd0:    chr_bank = {chr_regs[0][7:1], 1'b0};
      3'd1:    chr_bank = {chr_regs[0][7:1], 1'b1};
      3'd2:    chr_bank = {chr_regs[1][7:1], 1'b0};
      3'd3:    chr_bank = {chr_regs[1][7:1], 1'b1};
      3'd4:    chr_bank = chr_regs[2];
      3'd5:    chr_bank = chr_regs[3];
      3'd6:    chr_bank = chr_regs[4];
      3'd7:    chr_bank = chr_regs[5];
      default: chr_bank = 8'd0;
    endcase
    if (!chr_built) begin
      chr_bank = {5'd0, chr_slot};
    end
  end

  // PRG lookup with the bank number wrapped to the ROM size
  always_comb begin
    size_eff = prg_size;
    if (prg_size == 6'd0) begin
      size_eff = 6'd1;
    end else if (prg_size > 6'd32) begin
      size_eff = 6'd32;
    end
    size_mask_w = {size_eff, 1'b0} - 7'd1;
    prg_mask    = size_mask_w[5:0];
    prg_slot    = address[14:13];
    prg_bank    = (prg_slot == 2'd3) ? prg_mask : prg_banks[prg_slot];
  end

  // Next state and result for the current request
  always_comb begin
    chr_regs_next   = chr_regs;
    chr_built_next  = chr_built;
    chr_swap_next   = chr_swap;
    mirror_bit_next = mirror_bit;
    prg_banks_next  = prg_banks;
    unlock_next     = unlock;
    reload_next     = reload;
    control_next    = control;
    count_next      = count;
    pending_next    = pending;
    mapped          = 19'd0;
    case (mode)
      bmirq_pkg::MODE_WR: begin
        if (off inside {[bmirq_pkg::CHR_LO:bmirq_pkg::CHR_HI]}) begin
          chr_regs_next[3'(off - bmirq_pkg::CHR_LO)] = data;
          chr_built_next = 1'b1;
        end else if (off == bmirq_pkg::REG_MIRROR) begin
          mirror_bit_next = data[0];
          chr_swap_next   = data[1];
          chr_built_next  = 1'b1;
        end else if (off inside {[bmirq_pkg::UNLOCK_LO:bmirq_pkg::UNLOCK_HI]}) begin
          unlock_next[2'(off - bmirq_pkg::UNLOCK_LO)] = data;
        end else if (off inside {[bmirq_pkg::PRG_LO:bmirq_pkg::PRG_HI]}) begin
          prg_banks_next[2'(off - bmirq_pkg::PRG_LO)] = reverse6(data[5:0]);
        end else if (off == bmirq_pkg::REG_RELOAD) begin
          reload_next = data;
        end else if (off == bmirq_pkg::REG_CONTROL) begin
          control_next = data;
          if (!data[0]) begin
            count_next = reload_ctl;
          end
          if (!data[1]) begin
            pending_next = 1'b0;
          end
        end else if (off == bmirq_pkg::REG_IRQ_ACK) begin
          pending_next = 1'b0;
          count_next   = reload_ack;
        end
      end
      bmirq_pkg::MODE_TICK: begin
        count_next = count_tick;
        if ((count_tick == 13'd0) && control[1]) begin
          pending_next = 1'b1;
        end
      end
      bmirq_pkg::MODE_CHR: begin
        mapped = {1'b0, chr_bank, address[9:0]};
      end
      bmirq_pkg::MODE_PRG: begin
        mapped = {(prg_bank & prg_mask), address[12:0]};
      end
      default: begin
        mapped = 19'd0;
      end
    endcase
  end

  // Drive RAM request and register-side result
  always_comb begin
    ram_req.wr   = accept && (mode == bmirq_pkg::MODE_WR) && ram_open;
    ram_req.rd   = accept && (mode == bmirq_pkg::MODE_RD) && ram_open;
    ram_req.off  = off;
    ram_req.data = data;
    res.mapped   = mapped;
    res.irq      = pending_next;
    res.mirror   = mirror_bit_next;
  end

  // Commit state on accept; take size writes at any time
  always_ff @(posedge clk) begin
    if (rst) begin
      chr_regs   <= '0;
      chr_built  <= 1'b0;
      chr_swap   <= 1'b0;
      mirror_bit <= 1'b0;
      prg_banks  <= {bmirq_pkg::PRG_SLOT2_RESET, 6'd1, 6'd0};
      unlock     <= '0;
      reload     <= 8'd0;
      control    <= 8'd0;
      count      <= 13'd0;
      pending    <= 1'b0;
      prg_size   <= bmirq_pkg::PRG_SIZE_RESET;
    end else begin
      if (accept) begin
        chr_regs   <= chr_regs_next;
        chr_built  <= chr_built_next;
        chr_swap   <= chr_swap_next;
        mirror_bit <= mirror_bit_next;
        prg_banks  <= prg_banks_next;
        unlock     <= unlock_next;
        reload     <= reload_next;
        control    <= control_next;
        count      <= count_next;
        pending    <= pending_next;
      end
      if (cfg_wr_en) begin
        prg_size <= cfg_wr_data;
      end
    end
  end

endmodule

`default_nettype wire

[sv/bmirq_ram.sv]
// ----------------------------------------------------------------------------
// bmirq_ram
// Work RAM with a registered read, per-page first-byte registers and a
// clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module bmirq_ram #(
  parameter int RAM_BYTES = 5120
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire bmirq_pkg::ram_req_t req,
  output logic                     busy,
  output logic [7:0]               read_data
);

  localparam int AW    = $clog2(RAM_BYTES);
  localparam int NPAGE = (RAM_BYTES + 1023) / 1024;
  localparam int PW    = (NPAGE > 1) ? $clog2(NPAGE) : 1;

  logic [7:0]    mem [RAM_BYTES];
  logic [7:0]    mem_q;
  logic [7:0]    page_regs [NPAGE];
  logic [AW-1:0] clr_cnt;
  logic          rd_q;
  logic          pstart_q;
  logic [PW-1:0] pidx_q;
  logic [PW-1:0] req_pidx;
  logic          req_pstart;
  logic [7:0]    rd_byte;

  assign req_pidx   = req.off[10 +: PW];
  assign req_pstart = (req.off[9:0] == 10'd0);

  // Sweep zeros through the array after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_cnt <= '0;
    end else if (busy) begin
      if (clr_cnt == AW'(RAM_BYTES - 1)) begin
        busy <= 1'b0;
      end
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // Single write port, registered read
  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_cnt] <= 8'd0;
    end else if (req.wr) begin
      mem[req.off[AW-1:0]] <= req.data;
    end
    if (req.rd) begin
      mem_q <= mem[req.off[AW-1:0]];
    end
  end

  // Hold read-stage tags
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_q <= 1'b0;
    end else begin
      rd_q <= req.rd;
    end
    pstart_q <= req_pstart;
    pidx_q   <= req_pidx;
  end

  // Page first bytes live in the page registers
  assign rd_byte   = pstart_q ? page_regs[pidx_q] : mem_q;
  assign read_data = rd_q ? rd_byte : 8'd0;

  // Copy each access into its page's first byte; the younger write wins
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NPAGE; i++) begin
        page_regs[i] <= 8'd0;
      end
    end else begin
      for (int i = 0; i < NPAGE; i++) begin
        if (req.wr && (req_pidx == PW'(i))) begin
          page_regs[i] <= req.data;
        end else if (rd_q && (pidx_q == PW'(i))) begin
          page_regs[i] <= rd_byte;
        end
      end
    end
  end

endmodule

`default_nettype wire

[sv/bmirq_outq.sv]
// ----------------------------------------------------------------------------
// bmirq_outq
// Small result queue between the read stage and the output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module bmirq_outq (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire bmirq_pkg::out_item_t push_item,
  input  wire logic                 pop,
  output bmirq_pkg::out_item_t      head,
  output logic                      not_empty,
  output logic [2:0]                level
);

  localparam int PTR_W = $clog2(bmirq_pkg::OQ_DEPTH);

  bmirq_pkg::out_item_t slots [bmirq_pkg::OQ_DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;

  assign head      = slots[rptr];
  assign not_empty = (level != 3'd0);

  // Store pushed results
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_item;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      level <= 3'd0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      level <= level + {2'b00, push} - {2'b00, pop};
    end
  end

endmodule

`default_nettype wire

[sv/bank_mapper_irq_timer_paged_ram.sv]
// ----------------------------------------------------------------------------
// bank_mapper_irq_timer_paged_ram
// Cartridge bank mapper: register window, IRQ down counter, CHR/PRG address
// translation and a lockable paged work RAM.
// ----------------------------------------------------------------------------
//
//  port group  dir  bits  contents (low bit first)
//  s_*         in   32    mode[2:0], address[17:3], data[25:18]
//  m_*         out  32    read_data[7:0], mapped_address[26:8], irq[27],
//                         mirror_vertical[28]
//  cfg_*       in   6     prg_size_16k
//
//  One request per cycle while s_tready is high; each result passes through
//  the registered RAM read and then the write into the result queue.
//  After reset the RAM is cleared with s_tready low.
//  A four-entry result queue keeps requests flowing while m_tready is low
//  until it fills.
// ----------------------------------------------------------------------------
`default_nettype none

module bank_mapper_irq_timer_paged_ram #(
  parameter int RAM_BYTES = 5120
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,     // mode, address, data
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,     // read_data, mapped_address, irq, mirror_vertical
  input  wire logic        cfg_wr_en,
  input  wire logic [5:0]  cfg_wr_data  // prg_size_16k
);

  logic                   accept;
  logic                   busy;
  logic                   pop;
  logic [2:0]             level;
  logic [7:0]             read_data;
  logic                   s1_valid;
  bmirq_pkg::item_res_t   res;
  bmirq_pkg::item_res_t   s1_res;
  bmirq_pkg::ram_req_t    ram_req;
  bmirq_pkg::out_item_t   push_item;
  bmirq_pkg::out_item_t   head;

  // Accept while the queue can take everything in flight
  assign s_tready = !busy && ((4'(level) + 4'(s1_valid)) <= 4'd3);
  assign accept   = s_tvalid && s_tready;
  assign pop      = m_tvalid && m_tready;

  bmirq_regs #(
    .RAM_BYTES (RAM_BYTES)
  ) u_regs (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .mode        (bmirq_pkg::mode_t'(s_tdata[2:0])),
    .address     (s_tdata[17:3]),
    .data        (s_tdata[25:18]),
    .ram_req     (ram_req),
    .res         (res)
  );

  bmirq_ram #(
    .RAM_BYTES (RAM_BYTES)
  ) u_ram (
    .clk       (clk),
    .rst       (rst),
    .req       (ram_req),
    .busy      (busy),
    .read_data (read_data)
  );

  // Hold register-side results alongside the RAM read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    s1_res <= res;
  end

  always_comb begin
    push_item.mirror    = s1_res.mirror;
    push_item.irq       = s1_res.irq;
    push_item.mapped    = s1_res.mapped;
    push_item.read_data = read_data;
  end

  bmirq_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (s1_valid),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .not_empty (m_tvalid),
    .level     (level)
  );

  assign m_tdata = {3'b000, head};

endmodule

`default_nettype wire

[sim/bank_mapper_irq_timer_paged_ram_test.sv]
// ----------------------------------------------------------------------------
// bank_mapper_irq_timer_paged_ram_test
// Self-checking bench for the bank mapper. Requests are driven on the s_*
// stream and tracked by a scoreboard that keeps its own copy of the mapper
// registers, the IRQ counter and the work RAM. Every request yields one
// result, and each result on m_* is compared field by field in order.
// A directed opening is followed by random phases that sweep the PRG size
// and the sender and receiver idle patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module bank_mapper_irq_timer_paged_ram_test;

  localparam int          WRAM_BYTES   = 5120;
  localparam logic [12:0] PAGE_MASK    = 13'h1c00;
  localparam logic [12:0] WINDOW_SPARE = 13'h1400;
  localparam logic [2:0]  MODE_SPARE_LO = 3'd5;
  localparam logic [2:0]  MODE_SPARE_HI = 3'd7;
  // IRQ control bits
  localparam int CTL_RUN  = 0;
  localparam int CTL_IRQ  = 1;
  localparam int CTL_HALT = 2;
  localparam int PHASES         = 8;
  localparam int PHASE_REQUESTS = 153;
  localparam longint STOP_AFTER = 64'd3_000_000;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;      // mode[2:0], address[17:3], data[25:18]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;           // read_data[7:0], mapped_address[26:8],
                                  // irq[27], mirror_vertical[28]
  logic        cfg_wr_en = 1'b0;
  logic [5:0]  cfg_wr_data = '0;  // prg_size_16k

  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // --------------------------------------------------------------------------
  // Scoreboard: mapper state copy and the queue of results still due
  // --------------------------------------------------------------------------
  class mapper_tracker;
    logic [7:0]  chr_regs[6];
    logic [7:0]  chr_slots[8];
    logic [2:0]  chr_xor;
    logic [5:0]  prg_banks[3];
    logic        mirror;
    logic [7:0]  unlock[3];
    logic [7:0]  reload_val;
    logic [7:0]  control;
    logic [12:0] down_count;
    logic        irq_flag;
    logic [7:0]  wram[WRAM_BYTES];
    logic [5:0]  prg_size;
    bmirq_pkg::out_item_t due_results[$];
    int          errors;

    function new();
      foreach (chr_regs[i]) chr_regs[i] = '0;
      foreach (chr_slots[i]) chr_slots[i] = 8'(i);
      foreach (unlock[i]) unlock[i] = '0;
      foreach (wram[i]) wram[i] = '0;
      chr_xor = '0;
      prg_banks[0] = 6'd0;
      prg_banks[1] = 6'd1;
      prg_banks[2] = bmirq_pkg::PRG_SLOT2_RESET;
      mirror = 1'b0;
      reload_val = '0;
      control = '0;
      down_count = '0;
      irq_flag = 1'b0;
      prg_size = bmirq_pkg::PRG_SIZE_RESET;
      errors = 0;
    endfunction

    function void set_prg_size(logic [5:0] v);
      prg_size = v;
    endfunction

    // Recompute the eight 1 KB CHR slots from the bank registers
    function void rebuild_chr();
      chr_slots[3'd0 ^ chr_xor] = chr_regs[0] & 8'hfe;
      chr_slots[3'd1 ^ chr_xor] = chr_regs[0] | 8'h01;
      chr_slots[3'd2 ^ chr_xor] = chr_regs[1] & 8'hfe;
      chr_slots[3'd3 ^ chr_xor] = chr_regs[1] | 8'h01;
      chr_slots[3'd4 ^ chr_xor] = chr_regs[2];
      chr_slots[3'd5 ^ chr_xor] = chr_regs[3];
      chr_slots[3'd6 ^ chr_xor] = chr_regs[4];
      chr_slots[3'd7 ^ chr_xor] = chr_regs[5];
    endfunction

    function bit ram_unlocked(logic [12:0] off);
      if (int'(off) >= WRAM_BYTES) return 1'b0;
      return (off < bmirq_pkg::REGION0_END && unlock[0] == bmirq_pkg::UNLOCK0_KEY) ||
             (off < bmirq_pkg::REGION1_END && unlock[1] == bmirq_pkg::UNLOCK1_KEY) ||
             (off < bmirq_pkg::REGION2_END && unlock[2] == bmirq_pkg::UNLOCK2_KEY);
    endfunction

    function logic [12:0] reload_count(int add, logic [12:0] zero_count);
      if (reload_val == 0) return zero_count;
      return 13'((int'(reload_val) + add) * 16);
    endfunction

    // Apply one accepted request and queue the result it should produce
    function void note_request(logic [2:0] m, logic [14:0] a, logic [7:0] d);
      logic [12:0] off;
      logic [5:0]  rev;
      logic [5:0]  mask;
      logic [5:0]  bank;
      int          size;
      bmirq_pkg::out_item_t want;
      off = a[12:0];
      want = '0;
      case (m)
        bmirq_pkg::MODE_WR: begin
          if (off >= bmirq_pkg::CHR_LO && off <= bmirq_pkg::CHR_HI) begin
            chr_regs[off - bmirq_pkg::CHR_LO] = d;
            rebuild_chr();
          end else if (off == bmirq_pkg::REG_MIRROR) begin
            mirror = d[0];
            chr_xor = {d[1], 2'b00};
            rebuild_chr();
          end else if (off >= bmirq_pkg::UNLOCK_LO && off <= bmirq_pkg::UNLOCK_HI) begin
            unlock[off - bmirq_pkg::UNLOCK_LO] = d;
          end else if (off >= bmirq_pkg::PRG_LO && off <= bmirq_pkg::PRG_HI) begin
            for (int i = 0; i < 6; i++) rev[5 - i] = d[i];
            prg_banks[off - bmirq_pkg::PRG_LO] = rev;
          end else if (off == bmirq_pkg::REG_RELOAD) begin
            reload_val = d;
          end else if (off == bmirq_pkg::REG_CONTROL) begin
            control = d;
            if (!d[CTL_RUN]) down_count = reload_count(2, 13'd17);
            if (!d[CTL_IRQ]) irq_flag = 1'b0;
          end else if (off == bmirq_pkg::REG_IRQ_ACK) begin
            irq_flag = 1'b0;
            down_count = reload_count(1, 13'd1);
          end
          if (ram_unlocked(off)) begin
            wram[off] = d;
            wram[off & PAGE_MASK] = d;
          end
        end
        bmirq_pkg::MODE_RD: begin
          if (ram_unlocked(off)) begin
            want.read_data = wram[off];
            wram[off & PAGE_MASK] = wram[off];
          end
        end
        bmirq_pkg::MODE_TICK: begin
          if (control[CTL_RUN] && !control[CTL_HALT] && down_count != 0)
            down_count = down_count - 13'd1;
          if (down_count == 0 && control[CTL_IRQ]) irq_flag = 1'b1;
        end
        bmirq_pkg::MODE_CHR: begin
          want.mapped = {1'b0, chr_slots[off[12:10]], off[9:0]};
        end
        bmirq_pkg::MODE_PRG: begin
          size = int'(prg_size);
          if (size == 0) size = 1;
          if (size > 32) size = 32;
          mask = 6'(2 * size - 1);
          bank = (a[14:13] == 2'd3) ? mask : prg_banks[a[14:13]];
          want.mapped = {bank & mask, a[12:0]};
        end
        default: ;
      endcase
      want.irq = irq_flag;
      want.mirror = mirror;
      due_results.push_back(want);
    endfunction

    function void check_result(logic [31:0] word);
      bmirq_pkg::out_item_t got;
      bmirq_pkg::out_item_t want;
      got = word[28:0];
      if (due_results.size() == 0) begin
        $error("result %h arrived with no request outstanding", word);
        errors++;
        return;
      end
      want = due_results.pop_front();
      if (got.read_data !== want.read_data) begin
        $error("read_data expected %h actual %h", want.read_data, got.read_data);
        errors++;
      end
      if (got.mapped !== want.mapped) begin
        $error("mapped_address expected %h actual %h", want.mapped, got.mapped);
        errors++;
      end
      if (got.irq !== want.irq) begin
        $error("irq expected %b actual %b", want.irq, got.irq);
        errors++;
      end
      if (got.mirror !== want.mirror) begin
        $error("mirror_vertical expected %b actual %b", want.mirror, got.mirror);
        errors++;
      end
    endfunction
  endclass

  mapper_tracker board;

  bank_mapper_irq_timer_paged_ram #(
    .RAM_BYTES(WRAM_BYTES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #(STOP_AFTER);
    $display("simulation failed");
    $finish;
  end

  // Result side: check accepted results, stall at random
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) board.check_result(m_tdata);
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one request, with an optional random gap, and hold it until taken
  task automatic send_request(input logic [2:0] m, input logic [14:0] a,
                              input logic [7:0] d);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'd0, d, a, m};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_request(m, a, d);
  endtask

  // Drop valid and hold until every queued result has been checked
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (board.due_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_prg_size(input logic [5:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.set_prg_size(v);
  endtask

  // Build one random request; mostly meaningful traffic, some noise
  task automatic random_request(output bit counted);
    logic [7:0]  keys[3] = '{bmirq_pkg::UNLOCK0_KEY, bmirq_pkg::UNLOCK1_KEY,
                             bmirq_pkg::UNLOCK2_KEY};
    int          pick;
    logic [2:0]  m;
    logic [14:0] a;
    logic [7:0]  d;
    logic [12:0] off;
    pick = $urandom_range(99);
    a = 15'($urandom);
    d = 8'($urandom);
    counted = 1'b1;
    if (pick < 22) begin
      // register write, biased toward unlock keys and short reloads
      m = bmirq_pkg::MODE_WR;
      off = bmirq_pkg::CHR_LO + 13'($urandom_range(0, 15));
      a[12:0] = off;
      if (off >= bmirq_pkg::UNLOCK_LO && off <= bmirq_pkg::UNLOCK_HI &&
          $urandom_range(99) < 70)
        d = keys[off - bmirq_pkg::UNLOCK_LO];
      if (off == bmirq_pkg::REG_RELOAD && $urandom_range(99) < 60)
        d = 8'($urandom_range(0, 2));
      if (off == bmirq_pkg::REG_CONTROL && $urandom_range(99) < 75)
        d[CTL_HALT] = 1'b0;
    end else if (pick < 36) begin
      m = bmirq_pkg::MODE_WR;
      a[12:0] = 13'($urandom_range(0, 13'h17ff));
    end else if (pick < 50) begin
      m = bmirq_pkg::MODE_RD;
      a[12:0] = 13'($urandom_range(0, 13'h17ff));
    end else if (pick < 74) begin
      m = bmirq_pkg::MODE_TICK;
    end else if (pick < 85) begin
      m = bmirq_pkg::MODE_CHR;
    end else if (pick < 96) begin
      m = bmirq_pkg::MODE_PRG;
    end else if (pick < 98) begin
      m = 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
      counted = 1'b0;
    end else begin
      // write to an unused window offset
      m = bmirq_pkg::MODE_WR;
      a[12:0] = 13'($urandom_range(WINDOW_SPARE, bmirq_pkg::CHR_LO - 13'd1));
      counted = 1'b0;
    end
    send_request(m, a, d);
  endtask

  initial begin
    int sizes[PHASES] = '{1, 32, 0, 63, 16, 4, 7, 2};
    int done;
    bit counted;
    board = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed opening at the reset PRG size
    send_request(bmirq_pkg::MODE_CHR, 15'h7fff, 8'h00);
    send_request(bmirq_pkg::MODE_PRG, 15'h5fff, 8'h00);
    send_request(bmirq_pkg::MODE_PRG, 15'h7fff, 8'hff);
    send_request(bmirq_pkg::MODE_RD, 15'h0000, 8'h00);
    send_request(bmirq_pkg::MODE_WR, 15'h0123, 8'hff);
    send_request(bmirq_pkg::MODE_WR, {2'b00, bmirq_pkg::UNLOCK_LO},
                 bmirq_pkg::UNLOCK0_KEY);
    send_request(bmirq_pkg::MODE_WR, {2'b00, bmirq_pkg::UNLOCK_LO + 13'd1},
                 bmirq_pkg::UNLOCK1_KEY);
    send_request(bmirq_pkg::MODE_WR, {2'b00, bmirq_pkg::UNLOCK_HI},
                 bmirq_pkg::UNLOCK2_KEY);
    send_request(bmirq_pkg::MODE_WR, 15'h0000, 8'hff);
    send_request(bmirq_pkg::MODE_WR, 15'h73ff, 8'h5a);
    send_request(bmirq_pkg::MODE_RD, 15'h1000, 8'h00);
    send_request(bmirq_pkg::MODE_RD, 15'h13ff, 8'h00);
    send_request(bmirq_pkg::MODE_RD, 15'h1500, 8'h00);
    send_request(bmirq_pkg::MODE_WR, {2'b11, bmirq_pkg::CHR_LO}, 8'hff);
    send_request(bmirq_pkg::MODE_WR, {2'b00, bmirq_pkg::REG_MIRROR}, 8'h03);
    send_request(bmirq_pkg::MODE_CHR, 15'h1000, 8'h00);
    send_request(bmirq_pkg::MODE_WR, {2'b00, bmirq_pkg::PRG_LO}, 8'h01);
    send_request(bmirq_pkg::MODE_PRG, 15'h0000, 8'h00);
    send_request(bmirq_pkg::MODE_WR, {2'b00, bmirq_pkg::REG_RELOAD}, 8'h00);
    send_request(bmirq_pkg::MODE_WR, {2'b00, bmirq_pkg::REG_CONTROL}, 8'h03);
    send_request(bmirq_pkg::MODE_WR, {2'b00, bmirq_pkg::REG_IRQ_ACK}, 8'h00);
    send_request(bmirq_pkg::MODE_TICK, 15'h0000, 8'h00);
    send_request(bmirq_pkg::MODE_TICK, 15'h0000, 8'h00);
    send_request(bmirq_pkg::MODE_WR, {2'b00, bmirq_pkg::REG_CONTROL}, 8'h00);
    send_request(MODE_SPARE_HI, 15'h7fff, 8'hff);

    // Random phases: new PRG size each time, rotating idle patterns
    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      write_prg_size(6'(sizes[p]));
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      done = 0;
      while (done < PHASE_REQUESTS) begin
        random_request(counted);
        if (counted) done++;
        // hold off the sender once until the pipeline is empty
        if (p == 2 && done == PHASE_REQUESTS / 2 && counted) drain_results();
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (board.errors == 0 && board.due_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

[bank_mapper_irq_timer_paged_ram.f]
sv/bmirq_pkg.sv
sv/bmirq_regs.sv
sv/bmirq_ram.sv
sv/bmirq_outq.sv
sv/bank_mapper_irq_timer_paged_ram.sv
sim/bank_mapper_irq_timer_paged_ram_test.sv
